FILE: rtl/core/enms_pkg.sv
// ----------------------------------------------------------------------------
// enms_pkg
// Types, codes and constants shared by the encoder notch motion sequencer.
// ----------------------------------------------------------------------------
package enms_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int LEVEL_W = 12;
  localparam int NOTCH_W = 8;
  localparam int DIST_W  = 16;
  localparam int WIN_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [1:0] {
    EV_EDGE  = 2'd0,
    EV_MOVE  = 2'd1,
    EV_TURN  = 2'd2,
    EV_SPEED = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    DRV_OFF = 2'd0,
    DRV_FWD = 2'd1,
    DRV_REV = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    ACT_IDLE = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_TURN = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LEFT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TURN    = 3'd4;

  localparam logic [LEVEL_W-1:0] TURN_LEVEL_RST  = 12'd1500;
  localparam logic [LEVEL_W-1:0] MOVE_LEFT_RST   = 12'd2000;
  localparam logic [LEVEL_W-1:0] MOVE_RIGHT_RST  = 12'd1700;
  localparam logic [NOTCH_W-1:0] QUARTER_RST     = 8'd8;
  localparam logic [NOTCH_W-1:0] HALF_RST        = 8'd15;

  // target trim: n above 20 becomes n - 6 - n/20, n/20 = ((n >> 2) * 52429) >> 18
  localparam logic [DIST_W-1:0] TRIM_MIN    = 16'd20;
  localparam logic [DIST_W-1:0] TRIM_OFS    = 16'd6;
  localparam logic [15:0]       DIV5_MUL    = 16'd52429;
  localparam int                DIV5_SHIFT  = 18;
  localparam int                QUOT_W      = 12;

  typedef struct packed {
    event_t              mode;
    logic                wheel;
    logic [DIST_W-1:0]   notches;
    logic                turn_left;
    logic                half_turn;
  } in_item_t;

  typedef struct packed {
    drive_t              left_drive;
    drive_t              right_drive;
    logic [LEVEL_W-1:0]  left_level;
    logic [LEVEL_W-1:0]  right_level;
    action_t             action;
    logic                finished;
    logic                speed_valid;
    logic [WIN_W-1:0]    left_window_count;
    logic [WIN_W-1:0]    right_window_count;
  } out_item_t;

endpackage

FILE: rtl/core/enms_if.sv
// ----------------------------------------------------------------------------
// enms_in_if / enms_out_if
// Valid/ready channels carrying sequencer events and sequencer results.
// ----------------------------------------------------------------------------
interface enms_in_if;
  logic               valid;
  logic               ready;
  enms_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface enms_out_if;
  logic                valid;
  logic                ready;
  enms_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/core/encoder_notch_motion_sequencer.sv
// ----------------------------------------------------------------------------
// encoder_notch_motion_sequencer
// Two-wheel move/turn sequencer counting encoder notches, with speed windows.
// ----------------------------------------------------------------------------
// Results are registered. Throughput: one request per cycle while the skid
// stage is empty; a two-entry output register and skid stage keep the input
// open for one request while a result is stalled.
// Reset (synchronous, rst_n low): configuration returns to its defaults, the
// mode goes idle, drives off, levels and all counts clear.
// ----------------------------------------------------------------------------
module encoder_notch_motion_sequencer #(
  parameter int COUNT_BITS = enms_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  enms_in_if.sink                           in_chan,
  enms_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [enms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [enms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import enms_pkg::*;

  localparam int CMP_W = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
  localparam int PROD_W = DIST_W - 2 + 16;

  logic [LEVEL_W-1:0] turn_level_r, move_left_r, move_right_r;
  logic [NOTCH_W-1:0] quarter_r, half_r;

  action_t            act_r, act_nxt;
  logic               turn_half_r, turn_half_nxt;
  logic [COUNT_BITS-1:0] lturn_r, lturn_nxt, rturn_r, rturn_nxt;
  logic [COUNT_BITS-1:0] lmove_r, lmove_nxt, rmove_r, rmove_nxt;
  logic [COUNT_BITS-1:0] lspd_r, lspd_nxt, rspd_r, rspd_nxt;
  logic [DIST_W-1:0]  target_r, target_nxt;
  drive_t             drvl_r, drvl_nxt, drvr_r, drvr_nxt;
  logic [LEVEL_W-1:0] lvll_r, lvll_nxt, lvlr_r, lvlr_nxt;

  out_item_t          res, out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               accept;

  logic [PROD_W-1:0]  quot_prod;
  logic [QUOT_W-1:0]  quot;
  logic [DIST_W-1:0]  trimmed;
  logic [DIST_W-1:0]  cur_tgt;
  logic [CMP_W-1:0]   lcnt_ext, rcnt_ext;
  logic               l_done, r_done;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [WIN_W-1:0] cap_win(input logic [COUNT_BITS-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    cap_win = (ext > CMP_W'({WIN_W{1'b1}})) ? {WIN_W{1'b1}} : ext[WIN_W-1:0];
  endfunction

  assign in_chan.ready  = !skid_valid_r;
  assign accept         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.item  = out_r;

  assign quot_prod = PROD_W'(in_chan.item.notches[DIST_W-1:2]) * PROD_W'(DIV5_MUL);
  assign quot      = quot_prod[DIV5_SHIFT +: QUOT_W];
  assign trimmed   = (in_chan.item.notches > TRIM_MIN)
                   ? in_chan.item.notches - TRIM_OFS - DIST_W'(quot)
                   : in_chan.item.notches;

  always_comb begin
    act_nxt       = act_r;
    turn_half_nxt = turn_half_r;
    lturn_nxt     = lturn_r;
    rturn_nxt     = rturn_r;
    lmove_nxt     = lmove_r;
    rmove_nxt     = rmove_r;
    lspd_nxt      = lspd_r;
    rspd_nxt      = rspd_r;
    target_nxt    = target_r;
    drvl_nxt      = drvl_r;
    drvr_nxt      = drvr_r;
    lvll_nxt      = lvll_r;
    lvlr_nxt      = lvlr_r;
    res           = '0;
    cur_tgt       = '0;
    lcnt_ext      = '0;
    rcnt_ext      = '0;
    l_done        = 1'b0;
    r_done        = 1'b0;

    unique case (in_chan.item.mode)
      EV_EDGE: begin
        if (!in_chan.item.wheel) begin
          if (act_r == ACT_MOVE) lmove_nxt = sat_inc(lmove_r);
          else if (act_r == ACT_TURN) lturn_nxt = sat_inc(lturn_r);
          lspd_nxt = sat_inc(lspd_r);
        end else begin
          if (act_r == ACT_MOVE) rmove_nxt = sat_inc(rmove_r);
          else if (act_r == ACT_TURN) rturn_nxt = sat_inc(rturn_r);
          rspd_nxt = sat_inc(rspd_r);
        end
        if (act_r == ACT_TURN) begin
          cur_tgt  = DIST_W'(turn_half_r ? half_r : quarter_r);
          lcnt_ext = CMP_W'(lturn_nxt);
          rcnt_ext = CMP_W'(rturn_nxt);
        end else begin
          cur_tgt  = target_r;
          lcnt_ext = CMP_W'(lmove_nxt);
          rcnt_ext = CMP_W'(rmove_nxt);
        end
        l_done = lcnt_ext >= CMP_W'(cur_tgt);
        r_done = rcnt_ext >= CMP_W'(cur_tgt);
        if (act_r != ACT_IDLE) begin
          if (l_done) drvl_nxt = DRV_OFF;
          if (r_done) drvr_nxt = DRV_OFF;
          if (l_done && r_done) begin
            if (act_r == ACT_TURN) begin
              lturn_nxt = '0;
              rturn_nxt = '0;
            end else begin
              lmove_nxt = '0;
              rmove_nxt = '0;
            end
            act_nxt      = ACT_IDLE;
            res.finished = 1'b1;
          end
        end
      end
      EV_MOVE: begin
        target_nxt = trimmed;
        lmove_nxt  = '0;
        rmove_nxt  = '0;
        act_nxt    = ACT_MOVE;
        lvll_nxt   = move_left_r;
        lvlr_nxt   = move_right_r;
        drvl_nxt   = DRV_FWD;
        drvr_nxt   = DRV_FWD;
      end
      EV_TURN: begin
        act_nxt       = ACT_TURN;
        turn_half_nxt = in_chan.item.half_turn;
        lvll_nxt      = turn_level_r;
        lvlr_nxt      = turn_level_r;
        drvl_nxt      = in_chan.item.turn_left ? DRV_REV : DRV_FWD;
        drvr_nxt      = in_chan.item.turn_left ? DRV_FWD : DRV_REV;
      end
      EV_SPEED: begin
        res.speed_valid        = 1'b1;
        res.left_window_count  = cap_win(lspd_r);
        res.right_window_count = cap_win(rspd_r);
        lspd_nxt               = '0;
        rspd_nxt               = '0;
      end
      default: begin
      end
    endcase

    res.left_drive  = drvl_nxt;
    res.right_drive = drvr_nxt;
    res.left_level  = lvll_nxt;
    res.right_level = lvlr_nxt;
    res.action      = act_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_level_r <= TURN_LEVEL_RST;
      move_left_r  <= MOVE_LEFT_RST;
      move_right_r <= MOVE_RIGHT_RST;
      quarter_r    <= QUARTER_RST;
      half_r       <= HALF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TURN_LEVEL:   turn_level_r <= cfg_data;
        CFG_MOVE_LEFT:    move_left_r  <= cfg_data;
        CFG_MOVE_RIGHT:   move_right_r <= cfg_data;
        CFG_QUARTER_TURN: quarter_r    <= cfg_data[NOTCH_W-1:0];
        CFG_HALF_TURN:    half_r       <= cfg_data[NOTCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= ACT_IDLE;
      turn_half_r <= 1'b0;
      lturn_r     <= '0;
      rturn_r     <= '0;
      lmove_r     <= '0;
      rmove_r     <= '0;
      lspd_r      <= '0;
      rspd_r      <= '0;
      target_r    <= '0;
      drvl_r      <= DRV_OFF;
      drvr_r      <= DRV_OFF;
      lvll_r      <= '0;
      lvlr_r      <= '0;
    end else if (accept) begin
      act_r       <= act_nxt;
      turn_half_r <= turn_half_nxt;
      lturn_r     <= lturn_nxt;
      rturn_r     <= rturn_nxt;
      lmove_r     <= lmove_nxt;
      rmove_r     <= rmove_nxt;
      lspd_r      <= lspd_nxt;
      rspd_r      <= rspd_nxt;
      target_r    <= target_nxt;
      drvl_r      <= drvl_nxt;
      drvr_r      <= drvr_nxt;
      lvll_r      <= lvll_nxt;
      lvlr_r      <= lvlr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_finish_idles: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.item.finished |->
      out_chan.item.action == ACT_IDLE && out_chan.item.left_drive == DRV_OFF &&
      out_chan.item.right_drive == DRV_OFF)
    else $error("finished result with mode or drives still active");

  a_speed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.item.mode == EV_SPEED |=> lspd_r == '0 && rspd_r == '0)
    else $error("speed window counts not cleared after speed tick");

  a_move_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.item.mode == EV_MOVE |=>
      act_r == ACT_MOVE && lmove_r == '0 && rmove_r == '0)
    else $error("move start did not enter moving with cleared counts");
`endif

endmodule
